// ----- rtl/acpu_pkg.sv -----
// Package: constants, opcodes, state and struct types for the accumulator step unit.
`timescale 1ns / 1ps
`default_nettype none
package acpu_pkg;

   localparam int MEM_DEPTH = 256;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int DATA_W    = 32;
   localparam int CNT_W     = $clog2(DATA_W);
   localparam int ADDR_IN_W = 8;
   localparam int PC_OUT_W  = 8;
   localparam int STAT_W    = 3;

   localparam logic [DATA_W-1:0] OP_CLR   = 32'h0000_0000;
   localparam logic [DATA_W-1:0] OP_LOAD  = 32'h0000_0001;
   localparam logic [DATA_W-1:0] OP_ADD   = 32'h0000_0002;
   localparam logic [DATA_W-1:0] OP_SUB   = 32'h0000_0003;
   localparam logic [DATA_W-1:0] OP_MUL   = 32'h0000_0004;
   localparam logic [DATA_W-1:0] OP_DIV   = 32'h0000_0005;
   localparam logic [DATA_W-1:0] OP_OUT   = 32'h0000_0006;
   localparam logic [DATA_W-1:0] OP_JMP   = 32'h0000_0007;
   localparam logic [DATA_W-1:0] OP_BNZ   = 32'h0000_0008;
   localparam logic [DATA_W-1:0] OP_STORE = 32'h0000_0009;
   localparam logic [DATA_W-1:0] OP_HALT  = 32'h0000_00F4;

   typedef enum logic [STAT_W-1:0] {
      ST_OK      = 3'd0,
      ST_OUT     = 3'd1,
      ST_HALT    = 3'd2,
      ST_DIVZ    = 3'd3,
      ST_ILLEGAL = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_OPCODE,
      S_OPERAND,
      S_EXEC,
      S_WAIT,
      S_RESP
   } state_type;

   typedef enum logic [1:0] {
      MDU_IDLE,
      MDU_RUN,
      MDU_FIX
   } mdu_state_type;

   typedef enum logic [1:0] {
      MDU_MUL,
      MDU_DIV,
      MDU_MOD
   } mdu_op_type;

   typedef struct packed {
      logic              start;
      mdu_op_type        op;
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
   } mdu_req_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] result;
   } mdu_rsp_type;

endpackage
`default_nettype wire

// ----- rtl/acpu_if.sv -----
// Interfaces: request and response channels of the accumulator step unit.
`timescale 1ns / 1ps
`default_nettype none
interface acpu_req_if
   import acpu_pkg::*;
   ;
   logic                 valid;
   logic                 ready;
   logic                 kind;
   logic [ADDR_IN_W-1:0] address;
   logic [DATA_W-1:0]    value;

   modport source (output valid, output kind, output address, output value, input ready);
   modport sink   (input valid, input kind, input address, input value, output ready);
endinterface

interface acpu_rsp_if
   import acpu_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [STAT_W-1:0]   status;
   logic [DATA_W-1:0]   accumulator_value;
   logic [PC_OUT_W-1:0] program_counter;

   modport source (output valid, output status, output accumulator_value,
                   output program_counter, input ready);
   modport sink   (input valid, input status, input accumulator_value,
                   input program_counter, output ready);
endinterface
`default_nettype wire

// ----- rtl/acpu_ram.sv -----
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module acpu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ----- rtl/acpu_mdu.sv -----
// Bit-serial multiply / signed divide / unsigned remainder unit, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module acpu_mdu
   import acpu_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire mdu_req_type req,
   output mdu_rsp_type rsp
);

   mdu_state_type     state_ff, state_in;
   mdu_op_type        op_ff, op_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [DATA_W-1:0] p_ff, p_in;
   logic [DATA_W-1:0] m_ff, m_in;
   logic [DATA_W-1:0] q_ff, q_in;
   logic              neg_ff, neg_in;
   logic [DATA_W+1:0] trial;
   logic              sign_a, sign_b;

   assign sign_a = req.a[DATA_W-1];
   assign sign_b = req.b[DATA_W-1];
   assign trial  = {1'b0, p_ff, q_ff[DATA_W-1]} - {2'b00, m_ff};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         MDU_IDLE: begin
            if (req.start) state_in = MDU_RUN;
         end
         MDU_RUN: begin
            if (count_ff == CNT_W'(DATA_W - 1)) state_in = MDU_FIX;
         end
         MDU_FIX:  state_in = MDU_IDLE;
         default:  state_in = MDU_IDLE;
      endcase
   end

   always_comb begin
      op_in    = op_ff;
      count_in = count_ff;
      p_in     = p_ff;
      m_in     = m_ff;
      q_in     = q_ff;
      neg_in   = neg_ff;
      unique case (state_ff)
         MDU_IDLE: begin
            if (req.start) begin
               op_in    = req.op;
               count_in = '0;
               p_in     = '0;
               neg_in   = 1'b0;
               case (req.op)
                  MDU_DIV: begin
                     m_in   = sign_b ? (DATA_W'(0) - req.b) : req.b;
                     q_in   = sign_a ? (DATA_W'(0) - req.a) : req.a;
                     neg_in = sign_a ^ sign_b;
                  end
                  MDU_MUL: begin
                     m_in = req.a;
                     q_in = req.b;
                  end
                  default: begin
                     m_in = req.b;
                     q_in = req.a;
                  end
               endcase
            end
         end
         MDU_RUN: begin
            count_in = count_ff + CNT_W'(1);
            if (op_ff == MDU_MUL) begin
               p_in = p_ff + (q_ff[0] ? m_ff : '0);
               m_in = {m_ff[DATA_W-2:0], 1'b0};
               q_in = {1'b0, q_ff[DATA_W-1:1]};
            end else if (!trial[DATA_W+1]) begin
               p_in = trial[DATA_W-1:0];
               q_in = {q_ff[DATA_W-2:0], 1'b1};
            end else begin
               p_in = {p_ff[DATA_W-2:0], q_ff[DATA_W-1]};
               q_in = {q_ff[DATA_W-2:0], 1'b0};
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp.done = (state_ff == MDU_FIX);
      case (op_ff)
         MDU_DIV: rsp.result = neg_ff ? (DATA_W'(0) - q_ff) : q_ff;
         default: rsp.result = p_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MDU_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff    <= op_in;
      count_ff <= count_in;
      p_ff     <= p_in;
      m_ff     <= m_in;
      q_ff     <= q_in;
      neg_ff   <= neg_in;
   end

endmodule
`default_nettype wire

// ----- rtl/accumulator_cpu_step_unit.sv -----
// Top level: accumulator machine, one write or one instruction step per request beat.
//
//  channel  dir  handshake      payload
//  req_ch   in   valid / ready  kind, address, value
//  rsp_ch   out  valid / ready  status, accumulator_value, program_counter
//
//  One item at a time. Plain steps go from opcode fetch through operand fetch and execute to the response state.
//  MUL, nonzero DIV, JMP, taken BNZ and STORE go through the bit-serial unit
//  (32 iterations plus set-up and fix-up) before the response; memory writes do too.
//  Synchronous reset clears accumulator and pc; word memory is undefined until written.
//  The response register holds a finished beat while the next request is taken.
`timescale 1ns / 1ps
`default_nettype none
module accumulator_cpu_step_unit
   import acpu_pkg::*;
(
   input wire logic   clock,
   input wire logic   reset,
   acpu_req_if.sink   req_ch,
   acpu_rsp_if.source rsp_ch
);

   state_type         state_ff, state_in;
   logic              kind_ff, kind_in;
   logic [DATA_W-1:0] value_ff, value_in;
   logic [DATA_W-1:0] op_ff, op_in;
   logic [DATA_W-1:0] opnd_ff, opnd_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic [ADDR_W-1:0] pc_ff, pc_in;
   status_type        status_ff, status_in;

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]   rsp_acc_ff, rsp_acc_in;
   logic [PC_OUT_W-1:0] rsp_pc_ff, rsp_pc_in;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_addr;
   logic [DATA_W-1:0] ram_wdata;
   logic [DATA_W-1:0] ram_rdata;

   mdu_req_type       mdu_req;
   mdu_rsp_type       mdu_rsp;

   logic [ADDR_W:0]   pc_inc1, pc_inc2;
   logic [ADDR_W-1:0] next1, next2;
   logic [DATA_W-1:0] pc_wide;
   logic              req_beat;
   logic              rsp_load;

   assign pc_inc1 = {1'b0, pc_ff} + (ADDR_W+1)'(1);
   assign pc_inc2 = {1'b0, pc_ff} + (ADDR_W+1)'(2);
   assign next1   = (pc_inc1 >= (ADDR_W+1)'(MEM_DEPTH)) ?
                    ADDR_W'(pc_inc1 - (ADDR_W+1)'(MEM_DEPTH)) : pc_inc1[ADDR_W-1:0];
   assign next2   = (pc_inc2 >= (ADDR_W+1)'(MEM_DEPTH)) ?
                    ADDR_W'(pc_inc2 - (ADDR_W+1)'(MEM_DEPTH)) : pc_inc2[ADDR_W-1:0];
   assign pc_wide = DATA_W'(pc_in);

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_beat     = req_ch.valid && req_ch.ready;
   assign rsp_load     = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_ch.ready);

   acpu_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MEM_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   acpu_mdu u_mdu (
      .clock (clock),
      .reset (reset),
      .req   (mdu_req),
      .rsp   (mdu_rsp)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_beat) state_in = req_ch.kind ? S_OPCODE : S_WAIT;
         end
         S_OPCODE:  state_in = S_OPERAND;
         S_OPERAND: state_in = S_EXEC;
         S_EXEC: begin
            unique case (op_ff)
               OP_MUL, OP_JMP, OP_STORE: state_in = S_WAIT;
               OP_DIV:  state_in = (opnd_ff != '0) ? S_WAIT : S_RESP;
               OP_BNZ:  state_in = (acc_ff != '0) ? S_WAIT : S_RESP;
               default: state_in = S_RESP;
            endcase
         end
         S_WAIT: begin
            if (mdu_rsp.done) state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_load) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      kind_in   = kind_ff;
      value_in  = value_ff;
      op_in     = op_ff;
      opnd_in   = opnd_ff;
      acc_in    = acc_ff;
      pc_in     = pc_ff;
      status_in = status_ff;
      ram_we    = 1'b0;
      ram_addr  = pc_ff;
      ram_wdata = value_ff;
      mdu_req   = '{start: 1'b0, op: MDU_MOD, a: opnd_ff, b: DATA_W'(MEM_DEPTH)};
      unique case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               kind_in   = req_ch.kind;
               value_in  = req_ch.value;
               status_in = ST_OK;
               if (!req_ch.kind) begin
                  mdu_req.start = 1'b1;
                  mdu_req.a     = DATA_W'(req_ch.address);
               end
            end
         end
         S_OPCODE: begin
            op_in    = ram_rdata;
            ram_addr = next1;
         end
         S_OPERAND: begin
            opnd_in = ram_rdata;
         end
         S_EXEC: begin
            unique case (op_ff)
               OP_CLR: begin
                  acc_in = '0;
                  pc_in  = next1;
               end
               OP_LOAD: begin
                  acc_in = opnd_ff;
                  pc_in  = next2;
               end
               OP_ADD: begin
                  acc_in = acc_ff + opnd_ff;
                  pc_in  = next2;
               end
               OP_SUB: begin
                  acc_in = acc_ff - opnd_ff;
                  pc_in  = next2;
               end
               OP_MUL: begin
                  mdu_req = '{start: 1'b1, op: MDU_MUL, a: acc_ff, b: opnd_ff};
               end
               OP_DIV: begin
                  if (opnd_ff != '0) begin
                     mdu_req = '{start: 1'b1, op: MDU_DIV, a: acc_ff, b: opnd_ff};
                  end else begin
                     status_in = ST_DIVZ;
                     pc_in     = next2;
                  end
               end
               OP_OUT: begin
                  status_in = ST_OUT;
                  pc_in     = next1;
               end
               OP_JMP, OP_STORE: begin
                  mdu_req.start = 1'b1;
               end
               OP_BNZ: begin
                  if (acc_ff != '0) begin
                     mdu_req.start = 1'b1;
                  end else begin
                     pc_in = next2;
                  end
               end
               OP_HALT: status_in = ST_HALT;
               default: status_in = ST_ILLEGAL;
            endcase
         end
         S_WAIT: begin
            ram_addr = ADDR_W'(mdu_rsp.result);
            if (mdu_rsp.done) begin
               if (!kind_ff) begin
                  ram_we = 1'b1;
               end else begin
                  unique case (op_ff)
                     OP_MUL, OP_DIV: begin
                        acc_in = mdu_rsp.result;
                        pc_in  = next2;
                     end
                     OP_STORE: begin
                        ram_we    = 1'b1;
                        ram_wdata = acc_ff;
                        pc_in     = next2;
                     end
                     default: pc_in = ADDR_W'(mdu_rsp.result);
                  endcase
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_status_in = rsp_status_ff;
      rsp_acc_in    = rsp_acc_ff;
      rsp_pc_in     = rsp_pc_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_acc_in    = acc_ff;
         rsp_pc_in     = pc_wide[PC_OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         acc_ff       <= '0;
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff       <= kind_in;
      value_ff      <= value_in;
      op_ff         <= op_in;
      opnd_ff       <= opnd_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_acc_ff    <= rsp_acc_in;
      rsp_pc_ff     <= rsp_pc_in;
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.status            = rsp_status_ff;
   assign rsp_ch.accumulator_value = rsp_acc_ff;
   assign rsp_ch.program_counter   = rsp_pc_ff;

endmodule
`default_nettype wire
